// ----- hw/rtl/swra_pkg.sv -----
// ----------------------------------------------------------------------------
// swra_pkg
// Shared types and constants for the swap readahead window block.
// ----------------------------------------------------------------------------
`default_nettype none

package swra_pkg;

  // Field widths
  localparam int unsigned OffsetBits     = 32;
  localparam int unsigned MaxClusterLog2 = 6;
  localparam int unsigned CfgW           = 3;
  localparam int unsigned WinW           = 7;
  localparam int unsigned HitW           = 8;
  localparam int unsigned OutDataW       = WinW + 2 * OffsetBits + 1;

  // Reset values of the hit count and the cluster register, and the hit count ceiling
  localparam logic [CfgW-1:0] CfgReset = CfgW'(3);
  localparam logic [HitW-1:0] HitReset = HitW'(4);
  localparam logic [HitW-1:0] HitMax   = '1;

  // Event kinds carried in tuser
  typedef enum logic {
    OP_HIT = 1'b0,
    OP_REQ = 1'b1
  } swra_op_e;

  // Policy state
  typedef struct packed {
    logic [HitW-1:0]       hit_count;
    logic [OffsetBits-1:0] prev_off;
    logic [WinW-1:0]       last_win;
  } swra_state_t;

  // One result item
  typedef struct packed {
    logic                  do_readahead;
    logic [OffsetBits-1:0] range_end;
    logic [OffsetBits-1:0] range_start;
    logic [WinW-1:0]       window_pages;
  } swra_result_t;

endpackage : swra_pkg

`default_nettype wire

// ----- hw/rtl/swra_window.sv -----
// ----------------------------------------------------------------------------
// swra_window
// Window size and aligned slot range for one swap-in request, plus the
// policy state that the request leaves behind.
// ----------------------------------------------------------------------------
`default_nettype none

module swra_window (
  input  wire logic [swra_pkg::CfgW-1:0]       cluster_log2_i,
  input  wire logic [swra_pkg::OffsetBits-1:0] slot_offset_i,
  input  wire swra_pkg::swra_state_t           state_i,
  output swra_pkg::swra_state_t                state_o,
  output swra_pkg::swra_result_t               result_o
);
  import swra_pkg::*;

  logic [CfgW-1:0]       lg;
  logic [HitW:0]         hits_p2;
  logic [CfgW-1:0]       need;
  logic [CfgW-1:0]       wlog;
  logic                  adjacent;
  logic [WinW-1:0]       win;
  logic [WinW-1:0]       floor_w;
  logic [WinW-1:0]       win_f;
  logic [WinW-1:0]       mask;
  logic [OffsetBits-1:0] mask_x;
  logic [OffsetBits-1:0] start_raw;

  // Saturate the cluster register to the largest supported window
  assign lg = (cluster_log2_i > CfgW'(MaxClusterLog2)) ? CfgW'(MaxClusterLog2)
                                                       : cluster_log2_i;

  // Neighbor test against the last recorded offset (wraps)
  assign adjacent = (slot_offset_i == state_i.prev_off + OffsetBits'(1)) ||
                    (slot_offset_i == state_i.prev_off - OffsetBits'(1));

  // log2 of hits+2 rounded up, at least 2; above 64 clamps to 7 (capped below)
  assign hits_p2 = {1'b0, state_i.hit_count} + (HitW + 1)'(2);
  always_comb begin
    if (hits_p2 <= (HitW + 1)'(4)) begin
      need = CfgW'(2);
    end else if (hits_p2 <= (HitW + 1)'(8)) begin
      need = CfgW'(3);
    end else if (hits_p2 <= (HitW + 1)'(16)) begin
      need = CfgW'(4);
    end else if (hits_p2 <= (HitW + 1)'(32)) begin
      need = CfgW'(5);
    end else if (hits_p2 <= (HitW + 1)'(64)) begin
      need = CfgW'(6);
    end else begin
      need = CfgW'(7);
    end
  end

  // Pick the raw window, cap at the maximum, then hold at half the last one
  always_comb begin
    if (state_i.hit_count == '0) begin
      wlog = adjacent ? CfgW'(1) : CfgW'(0);
    end else begin
      wlog = (need > lg) ? lg : need;
    end
    win     = WinW'(1) << wlog;
    floor_w = state_i.last_win >> 1;
    win_f   = (win < floor_w) ? floor_w : win;
  end

  // Result and next state; a one-page maximum leaves the state alone
  always_comb begin
    state_o = state_i;
    if (lg == '0) begin
      mask = '0;
    end else begin
      mask               = win_f - WinW'(1);
      state_o.hit_count  = '0;
      state_o.last_win   = win_f;
      if (state_i.hit_count == '0) begin
        state_o.prev_off = slot_offset_i;
      end
    end
  end

  assign mask_x    = {{(OffsetBits - WinW){1'b0}}, mask};
  assign start_raw = slot_offset_i & ~mask_x;

  // Aligned range; slot zero holds the header and is skipped
  always_comb begin
    result_o.window_pages = mask + WinW'(1);
    result_o.do_readahead = (mask != '0);
    result_o.range_end    = slot_offset_i | mask_x;
    if (mask != '0 && start_raw == '0) begin
      result_o.range_start = OffsetBits'(1);
    end else begin
      result_o.range_start = start_raw;
    end
  end

endmodule : swra_window

`default_nettype wire

// ----- hw/rtl/swap_readahead_window.sv -----
// A request item goes through the input register, then the result register,
//   waiting in the input register while the result is held; hit items give no result.
// Throughput: one item per cycle, sustained; a held result stalls the input only
//   while a request waits behind it in the input register.
// Reset: hit count 4, previous offset 0, last window 0, cluster_log2 3.
// ----------------------------------------------------------------------------
// swap_readahead_window
// Adaptive swap-in readahead window policy with stream ports.
// ----------------------------------------------------------------------------
`default_nettype none

module swap_readahead_window (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [swra_pkg::CfgW-1:0]       cfg_wdata_i,    // cluster_log2
  // input items
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  input  wire logic [swra_pkg::OffsetBits-1:0] s_axis_tdata,   // slot_offset
  input  wire logic                            s_axis_tuser,   // opcode
  // result items
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // window_pages[6:0], range_start[38:7], range_end[70:39], do_readahead[71]
  output      logic [swra_pkg::OutDataW-1:0]   m_axis_tdata
);
  import swra_pkg::*;

  logic [CfgW-1:0]       cfg_q;
  swra_state_t           state_q, state_d, req_state;
  logic                  in_vld_q;
  swra_op_e              in_op_q;
  logic [OffsetBits-1:0] in_off_q;
  logic                  out_vld_q;
  swra_result_t          out_q, res;
  logic                  out_free;
  logic                  in_go;
  logic                  in_take;

  // Cluster register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Handshake: a hit always drains, a request needs room in the result reg
  assign out_free      = !out_vld_q || m_axis_tready;
  assign in_go         = in_vld_q && ((in_op_q == OP_HIT) || out_free);
  assign s_axis_tready = !in_vld_q || in_go;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q  <= swra_op_e'(s_axis_tuser);
      in_off_q <= s_axis_tdata;
    end
  end

  // Window logic
  swra_window u_window (
    .cluster_log2_i (cfg_q),
    .slot_offset_i  (in_off_q),
    .state_i        (state_q),
    .state_o        (req_state),
    .result_o       (res)
  );

  // Policy state update
  always_comb begin
    state_d = state_q;
    if (in_go) begin
      if (in_op_q == OP_HIT) begin
        if (state_q.hit_count != HitMax) begin
          state_d.hit_count = state_q.hit_count + HitW'(1);
        end
      end else begin
        state_d = req_state;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.hit_count <= HitReset;
      state_q.prev_off  <= '0;
      state_q.last_win  <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_go && (in_op_q == OP_REQ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go && (in_op_q == OP_REQ)) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // Checks
  a_win_pow2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(out_q.window_pages))
    else $error("window size not a power of two");

  a_ra_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.do_readahead == (out_q.window_pages != WinW'(1))))
    else $error("readahead flag disagrees with window size");

  a_range_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.range_start <= out_q.range_end))
    else $error("range start beyond range end");

  a_hit_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_go && (in_op_q == OP_HIT)) |=> (state_q.hit_count != '0))
    else $error("hit count zero after a hit");

endmodule : swap_readahead_window

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the swap readahead window block. A scoreboard class
// tracks the hit counter, the previous offset and the last window for every
// accepted item. It predicts each window and slot range, and it compares
// them with the result items field by field. Directed items come first. Then
// random phases run under several cluster sizes, with random sender bursts,
// receiver stall patterns and two long receiver hold-offs.
// ----------------------------------------------------------------------------

// Tracks the window policy state and holds the windows still to be seen
class window_scoreboard;
  logic [swra_pkg::CfgW-1:0]       cluster_log2;
  logic [swra_pkg::HitW-1:0]       hit_count;
  logic [swra_pkg::OffsetBits-1:0] prev_off;
  logic [swra_pkg::WinW-1:0]       last_win;
  swra_pkg::swra_result_t          pending_windows[$];
  int unsigned                     fail_count;

  function new();
    cluster_log2 = swra_pkg::CfgReset;
    hit_count    = swra_pkg::HitReset;
    prev_off     = '0;
    last_win     = '0;
    fail_count   = 0;
  endfunction

  function void set_cluster(logic [swra_pkg::CfgW-1:0] value);
    cluster_log2 = value;
  endfunction

  function int unsigned pending();
    return pending_windows.size();
  endfunction

  // Updates the state for one accepted item; a request queues its window
  function void note_event(swra_pkg::swra_op_e op, logic [swra_pkg::OffsetBits-1:0] off);
    int unsigned                     lg;
    int unsigned                     max_win;
    int unsigned                     win;
    int unsigned                     floor_win;
    int unsigned                     rounded;
    logic [swra_pkg::OffsetBits-1:0] mask;
    swra_pkg::swra_result_t          res;

    if (op == swra_pkg::OP_HIT) begin
      if (hit_count != swra_pkg::HitMax) hit_count++;
      return;
    end

    lg      = (cluster_log2 > swra_pkg::MaxClusterLog2) ? swra_pkg::MaxClusterLog2
                                                        : cluster_log2;
    max_win = 1 << lg;
    if (max_win <= 1) begin
      // single-page maximum: state untouched
      win = 1;
    end else begin
      win       = hit_count + 2;
      hit_count = '0;
      if (win == 2) begin
        // no hits: two pages only for a neighbor of the previous offset
        if (off != prev_off + 32'd1 && off != prev_off - 32'd1) win = 1;
        prev_off = off;
      end else begin
        rounded = 4;
        while (rounded < win) rounded <<= 1;
        win = rounded;
      end
      if (win > max_win) win = max_win;
      floor_win = last_win / 2;
      if (win < floor_win) win = floor_win;
      last_win = swra_pkg::WinW'(win);
    end

    mask = swra_pkg::OffsetBits'(win - 1);
    res.window_pages = swra_pkg::WinW'(win);
    if (mask == '0) begin
      res.range_start = off;
      res.range_end   = off;
    end else begin
      res.range_start = off & ~mask;
      res.range_end   = off | mask;
      // slot 0 is the swap header
      if (res.range_start == '0) res.range_start = 32'd1;
    end
    res.do_readahead = (mask != '0);
    pending_windows.push_back(res);
  endfunction

  // Compares one result item with the oldest predicted window
  function void check_window(swra_pkg::swra_result_t got);
    swra_pkg::swra_result_t exp;

    if (pending_windows.size() == 0) begin
      $error("unexpected result item: window_pages %0d, range_start %h",
             got.window_pages, got.range_start);
      fail_count++;
      return;
    end
    exp = pending_windows.pop_front();
    if (got.window_pages !== exp.window_pages) begin
      $error("window_pages: expected %0d, actual %0d", exp.window_pages, got.window_pages);
      fail_count++;
    end
    if (got.range_start !== exp.range_start) begin
      $error("range_start: expected %h, actual %h", exp.range_start, got.range_start);
      fail_count++;
    end
    if (got.range_end !== exp.range_end) begin
      $error("range_end: expected %h, actual %h", exp.range_end, got.range_end);
      fail_count++;
    end
    if (got.do_readahead !== exp.do_readahead) begin
      $error("do_readahead: expected %0d, actual %0d", exp.do_readahead, got.do_readahead);
      fail_count++;
    end
  endfunction
endclass

module tb_top;
  import swra_pkg::*;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CfgW-1:0]       cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OffsetBits-1:0] s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;

  window_scoreboard sb;

  // sender pacing and receiver hold-off request
  bit          pace_on;
  int unsigned burst_left;
  bit          hold_pending;

  swap_readahead_window u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result items
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_window(swra_result_t'(m_axis_tdata));
  end

  // Receiver: rotating stall pattern per stretch, long hold-off on request
  initial begin
    int unsigned stretch_left;
    int unsigned hold_left;
    logic [7:0]  stall_pat;

    stretch_left = 0;
    hold_left    = 0;
    stall_pat    = 8'hFF;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(8, 64);
          case ($urandom_range(0, 3))
            0:       stall_pat = 8'hFF;
            1:       stall_pat = 8'h11;
            2:       stall_pat = 8'h01;
            default: stall_pat = 8'($urandom) | 8'h01;
          endcase
        end
        stretch_left--;
        m_axis_tready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
    end
  end

  // Offers one item and waits for it to be taken
  task automatic send_item(input swra_op_e op, input logic [OffsetBits-1:0] off);
    if (pace_on) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    s_axis_tuser  <= op;
    s_axis_tdata  <= off;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_event(op, off);
  endtask

  task automatic send_hit();
    send_item(OP_HIT, OffsetBits'($urandom));
  endtask

  // Stops offering and lets every predicted window drain out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cluster(input logic [CfgW-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_cluster(value);
  endtask

  // Random mix: hit bursts, runs of neighboring offsets, scattered requests
  task automatic run_phase(input int unsigned n_items);
    int unsigned           count;
    int unsigned           len;
    logic [OffsetBits-1:0] cursor;

    count  = 0;
    cursor = OffsetBits'($urandom);
    while (count < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          len = $urandom_range(1, 7);
          repeat (len) send_hit();
          count += len;
        end
        3, 4, 5, 6: begin
          len = $urandom_range(1, 6);
          repeat (len) begin
            cursor = $urandom_range(0, 1) ? cursor + 32'd1 : cursor - 32'd1;
            send_item(OP_REQ, cursor);
          end
          count += len;
        end
        7: begin
          cursor = OffsetBits'($urandom);
          send_item(OP_REQ, cursor);
          count++;
        end
        8: begin
          cursor = OffsetBits'($urandom_range(0, 80));
          send_item(OP_REQ, cursor);
          count++;
        end
        default: begin
          cursor = 32'hFFFF_FFFF - OffsetBits'($urandom_range(0, 80));
          send_item(OP_REQ, cursor);
          count++;
        end
      endcase
    end
  endtask

  // Stimulus
  initial begin
    logic [CfgW-1:0] phase_cfg[8];
    int unsigned     waited;
    bit              saved_pace;

    phase_cfg  = '{3'd1, 3'd6, 3'd0, 3'd7, 3'd2, 3'd5, 3'd4, 3'd3};
    sb         = new();
    pace_on    = 1'b0;
    burst_left = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset hits, slot 0 skip, wrap-around neighbors, single page
    send_item(OP_REQ, 32'h0000_0000);
    send_item(OP_REQ, 32'hFFFF_FFFF);
    send_item(OP_REQ, 32'h0000_0000);
    send_item(OP_REQ, 32'h1234_5678);
    send_item(OP_REQ, 32'h1234_5679);
    repeat (3) send_hit();
    send_item(OP_REQ, 32'h0000_0005);
    send_hit();
    send_item(OP_REQ, 32'h8000_0000);
    settle();

    // single-page maximum keeps the hit count
    write_cluster(3'd0);
    send_item(OP_HIT, 32'hFFFF_FFFF);
    send_item(OP_REQ, 32'h0000_0000);
    send_item(OP_REQ, 32'hFFFF_FFFF);
    settle();

    // oversized cluster register saturates
    write_cluster(3'd7);
    send_item(OP_REQ, 32'hAAAA_AAAA);
    repeat (4) send_hit();
    send_item(OP_REQ, 32'h5555_5555);
    settle();

    foreach (phase_cfg[i]) begin
      write_cluster(phase_cfg[i]);
      pace_on    = (i % 2 == 0);
      burst_left = 0;
      run_phase(50);
      if (i == 1 || i == 5) begin
        // receiver holds off while requests keep coming back to back
        saved_pace   = pace_on;
        pace_on      = 1'b0;
        hold_pending = 1'b1;
        repeat (20) send_item(OP_REQ, OffsetBits'($urandom));
        pace_on = saved_pace;
      end
      if (i == 3) begin
        // hit counter saturation under the largest window
        repeat (270) send_hit();
        send_item(OP_REQ, OffsetBits'($urandom));
      end
      run_phase(50);
      settle();
    end

    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (6) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d predicted windows never arrived", sb.pending());
      sb.fail_count++;
    end

    if (sb.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
